/* hdl/arr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arr_pkg
// Shared constants, types and the crc-8 byte fold for the attitude responder.
// ----------------------------------------------------------------------------
package arr_pkg;

    // crc-8 polynomial, no reflection, init zero
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // register reset values
    localparam logic [7:0] HEADER_RESET  = 8'hCC;
    localparam logic [7:0] COMMAND_RESET = 8'h50;

    // configuration register indexes
    localparam logic [7:0] REG_HEADER  = 8'd0;
    localparam logic [7:0] REG_COMMAND = 8'd1;

    // receive phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_COMMAND = 2'd1;
    localparam logic [1:0] PH_CRC     = 2'd2;

    // answer packet: eight payload bytes, then crc
    localparam logic [3:0] LAST_IDX = 4'd8;

    // floor(x / 10) for x below 2^16 as (x * 52429) >> 19
    localparam logic [16:0] YAW_RECIP = 17'd52429;
    localparam int          YAW_SHIFT = 19;

    // receive status toward the top level
    typedef struct packed {
        logic fire;       // good attitude request completed this cycle
        logic crc_phase;  // waiting for the crc byte
    } t_rx_stat;

    // fold one byte into a running crc-8
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* hdl/attitude_request_responder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attitude_request_responder
// Parses crc-8 protected attitude requests and answers with the held attitude.
// ----------------------------------------------------------------------------
//  channel   | dir | word
//  s (tdata) | in  | link byte or attitude update, tuser selects
//  m (tdata) | out | answer byte, tlast on the crc byte
//  cfg       | in  | register index and write data
//
//  A new input word can be accepted every cycle while o_s_tready is high.
//  A good request starts a nine-byte answer the cycle after its crc byte,
//  then one byte per cycle while the sink is ready.
//  While an answer is pending, input stalls if the parser waits for a crc byte.
//  Reset is synchronous, active low; config writes complete at once.
// ----------------------------------------------------------------------------
module attitude_request_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // rx_byte[7:0], roll[23:8], pitch[39:24], yaw[55:40]
    input  logic [0:0]  i_s_tuser,   // func[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // tx_byte[7:0]
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]        r_hdr_byte;
    logic [7:0]        r_cmd_byte;
    logic              s_accept;
    arr_pkg::t_rx_stat rx_stat;
    logic [15:0]       held_roll, held_pitch, held_yd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_byte <= arr_pkg::HEADER_RESET;
            r_cmd_byte <= arr_pkg::COMMAND_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == arr_pkg::REG_HEADER) begin
                r_hdr_byte <= i_cfg_data;
            end else if (i_cfg_index == arr_pkg::REG_COMMAND) begin
                r_cmd_byte <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // input flow: in the crc phase the input waits for the answer buffer
    assign o_s_tready = !o_m_tvalid || !rx_stat.crc_phase;
    assign s_accept   = i_s_tvalid && o_s_tready;

    arr_rx u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (s_accept && !i_s_tuser[0]),
        .i_byte    (i_s_tdata[7:0]),
        .i_header  (r_hdr_byte),
        .i_command (r_cmd_byte),
        .o_stat    (rx_stat)
    );

    arr_att u_att (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_accept && i_s_tuser[0]),
        .i_roll  (i_s_tdata[23:8]),
        .i_pitch (i_s_tdata[39:24]),
        .i_yaw   (i_s_tdata[55:40]),
        .o_roll  (held_roll),
        .o_pitch (held_pitch),
        .o_yd    (held_yd)
    );

    arr_tx u_tx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (rx_stat.fire),
        .i_header  (r_hdr_byte),
        .i_command (r_cmd_byte),
        .i_roll    (held_roll),
        .i_pitch   (held_pitch),
        .i_yd      (held_yd),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata),
        .o_tlast   (o_m_tlast)
    );

endmodule

/* hdl/arr_att.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arr_att
// Holds the latest attitude; yaw is converted to whole degrees on update.
// ----------------------------------------------------------------------------
module arr_att (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [15:0] i_roll,
    input  logic [15:0] i_pitch,
    input  logic [15:0] i_yaw,
    output logic [15:0] o_roll,
    output logic [15:0] o_pitch,
    output logic [15:0] o_yd
);

    logic [15:0] r_roll, r_pitch, r_yd;
    logic [15:0] n_yd;
    logic [16:0] yaw_abs;
    logic [33:0] yaw_prod;
    logic [14:0] yaw_q;

    // yaw / 10 truncated toward zero: divide the magnitude, restore the sign
    always_comb begin
        yaw_abs  = i_yaw[15] ? (17'd0 - {i_yaw[15], i_yaw}) : {1'b0, i_yaw};
        yaw_prod = yaw_abs * arr_pkg::YAW_RECIP;
        yaw_q    = yaw_prod[arr_pkg::YAW_SHIFT +: 15];
        n_yd     = i_yaw[15] ? (16'd0 - {1'b0, yaw_q}) : {1'b0, yaw_q};
    end

    // held values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll  <= '0;
            r_pitch <= '0;
            r_yd    <= '0;
        end else if (i_load) begin
            r_roll  <= i_roll;
            r_pitch <= i_pitch;
            r_yd    <= n_yd;
        end
    end

    assign o_roll  = r_roll;
    assign o_pitch = r_pitch;
    assign o_yd    = r_yd;

endmodule

/* hdl/arr_rx.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arr_rx
// Receive parser: hunts the header, takes the command, checks the crc byte.
// ----------------------------------------------------------------------------
module arr_rx (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_en,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_header,
    input  logic [7:0]        i_command,
    output arr_pkg::t_rx_stat o_stat
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_crc, n_crc;
    logic       fire;

    // next phase, command and crc for one link byte
    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_crc   = r_crc;
        fire    = 1'b0;
        if (i_byte_en) begin
            case (r_phase)
                arr_pkg::PH_COMMAND: begin
                    n_cmd   = i_byte;
                    n_crc   = arr_pkg::crc8_fold(r_crc, i_byte);
                    n_phase = arr_pkg::PH_CRC;
                end
                arr_pkg::PH_CRC: begin
                    fire    = (i_byte == r_crc) && (r_cmd == i_command);
                    n_crc   = '0;
                    n_phase = arr_pkg::PH_HEADER;
                end
                default: begin
                    // header hunt, also the unused phase code
                    n_phase = arr_pkg::PH_HEADER;
                    if (i_byte == i_header) begin
                        n_crc   = arr_pkg::crc8_fold(8'd0, i_byte);
                        n_cmd   = '0;
                        n_phase = arr_pkg::PH_COMMAND;
                    end
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= arr_pkg::PH_HEADER;
            r_cmd   <= '0;
            r_crc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_crc   <= n_crc;
        end
    end

    assign o_stat.fire      = fire;
    assign o_stat.crc_phase = (r_phase == arr_pkg::PH_CRC);

endmodule

/* hdl/arr_tx.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arr_tx
// Answer serializer: snapshots eight payload bytes, sends them, then the crc.
// ----------------------------------------------------------------------------
module arr_tx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [7:0]  i_header,
    input  logic [7:0]  i_command,
    input  logic [15:0] i_roll,
    input  logic [15:0] i_pitch,
    input  logic [15:0] i_yd,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [7:0]  o_tdata,
    output logic        o_tlast
);

    logic        r_busy;
    logic [3:0]  r_idx;
    logic [63:0] r_shift;
    logic [7:0]  r_crc;
    logic        is_last;
    logic        send;

    assign is_last = (r_idx == arr_pkg::LAST_IDX);
    assign send    = r_busy && i_tready;

    // control: load a new answer, step through the bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (send) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // payload shift line and running crc over the sent bytes
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_shift <= {i_yd, i_pitch, i_roll, i_command, i_header};
            r_crc   <= '0;
        end else if (send && !is_last) begin
            r_shift <= {8'd0, r_shift[63:8]};
            r_crc   <= arr_pkg::crc8_fold(r_crc, r_shift[7:0]);
        end
    end

    assign o_tvalid = r_busy;
    assign o_tdata  = is_last ? r_crc : r_shift[7:0];
    assign o_tlast  = is_last;

endmodule

/* hdl/arr_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arr_chk
// Port-level checks on the answer stream of the attitude responder.
// ----------------------------------------------------------------------------
module arr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    // no answer word right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("answer valid after reset");

    // a stalled answer word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled answer word changed");

    // an answer has no gaps before its crc byte
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("gap inside answer");

    // answers never run back to back
    a_gap_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tlast |=> !o_m_tvalid)
        else $error("answer started right after crc byte");

    // config writes are never stalled
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write stalled");

endmodule

bind attitude_request_responder arr_chk u_arr_chk (.*);
